@@ design/rtpa_pkg.sv @@
// rtpa_pkg: constants, opcodes, kinds and controller states for the region table allocator
// no dependencies
package rtpa_pkg;
  localparam int MAX_REGIONS_DEF = 64;
  localparam logic [63:0] PAGE_BYTES = 64'h1000;
  localparam logic [63:0] SIZE_LOW_MASK = 64'hF;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ALIGN = 2'd1,
    OP_ALLOC = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  localparam logic [1:0] KIND_USED = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARD,
    ST_ADIV,
    ST_AWR,
    ST_SRD,
    ST_SCHK,
    ST_MRD,
    ST_MWR,
    ST_FIX,
    ST_QRD,
    ST_QACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] rem;
  } div_rsp_t;
endpackage

@@ design/rtpa_ram.sv @@
// rtpa_ram: generic single port ram, registered read
// depends on nothing
module rtpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/rtpa_div.sv @@
// rtpa_div: 64 bit restoring remainder unit, one bit a cycle
// depends on rtpa_pkg
module rtpa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rtpa_pkg::div_req_t req,
  output rtpa_pkg::div_rsp_t rsp
);
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] num_r, num_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] sh;
  logic [64:0] diff;

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r, num_r[63]};
    diff = sh - {1'b0, den_r};
    if (req.start) begin
      rem_nxt = '0;
      num_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      rem_nxt = (sh >= {1'b0, den_r}) ? diff[63:0] : sh[63:0];
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem = rem_r;
endmodule

@@ design/region_table_page_allocator_core.sv @@
// region_table_page_allocator_core: top level, region table in rams with a sequencer
// depends on rtpa_pkg, rtpa_ram, rtpa_div
//
// channel  direction  handshake          payload
// in_      in         start & !busy      opcode, load fields, align, request
// out_     out        out_valid 1 cycle  alloc, status, free summary, count
//
// load writes one entry if not full. query reads each entry. allocate scans
// down for a free entry, then shifts entries up. align runs two passes of the
// bit serial remainder unit per entry (base mod alignment, then size). reset
// clears control state and entry count only. results cannot be stalled.
module region_table_page_allocator_core #(
  parameter int MAX_REGIONS = rtpa_pkg::MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_load_base,
  input  logic [63:0] in_load_size,
  input  logic [1:0]  in_load_type,
  input  logic [63:0] in_align_value,
  input  logic [63:0] in_request_bytes,
  output logic        out_valid,
  output logic [63:0] out_alloc_address,
  output logic        out_alloc_ok,
  output logic        out_table_full,
  output logic [63:0] out_highest_free_top,
  output logic [63:0] out_total_free,
  output logic [6:0]  out_entry_count
);
  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  rtpa_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hit_r, hit_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic        rnd_bad_r, rnd_bad_nxt;
  logic        phase_r, phase_nxt;
  logic [63:0] tb_r, tb_nxt, ts_r, ts_nxt;
  logic [1:0]  tk_r, tk_nxt;
  logic [63:0] top_r, top_nxt, tot_r, tot_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic        ok_r, ok_nxt, full_r, full_nxt;

  logic          we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   wb, ws, rb, rs;
  logic [1:0]    wk, rk;
  rtpa_pkg::div_req_t dreq;
  rtpa_pkg::div_rsp_t drsp;

  rtpa_ram #(.WIDTH(64), .DEPTH(MAX_REGIONS)) u_base (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wb), .rdata(rb));
  rtpa_ram #(.WIDTH(64), .DEPTH(MAX_REGIONS)) u_size (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(ws), .rdata(rs));
  rtpa_ram #(.WIDTH(2), .DEPTH(MAX_REGIONS)) u_kind (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wk), .rdata(rk));
  rtpa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [63:0] shift_v, sz_v, sum_v;
  logic [11:0] pad_v;
  logic [64:0] rnd_v;

  always_comb begin
    pad_v = 12'd0 - in_request_bytes[11:0];
    rnd_v = {1'b0, in_request_bytes} + {53'd0, pad_v};
    shift_v = a_r - drsp.rem;
    sz_v = (ts_r >= shift_v) ? ts_r - shift_v : 64'd0;
    sum_v = rb + rs;
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    op_nxt = op_r;
    a_nxt = a_r;
    bytes_nxt = bytes_r;
    rnd_bad_nxt = rnd_bad_r;
    phase_nxt = phase_r;
    tb_nxt = tb_r;
    ts_nxt = ts_r;
    tk_nxt = tk_r;
    top_nxt = top_r;
    tot_nxt = tot_r;
    addr_nxt = addr_r;
    ok_nxt = ok_r;
    full_nxt = full_r;
    unique case (st_r)
      rtpa_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt = in_opcode;
          a_nxt = in_align_value;
          bytes_nxt = rnd_v[63:0];
          rnd_bad_nxt = rnd_v[64];
          tb_nxt = in_load_base;
          ts_nxt = in_load_size & ~rtpa_pkg::SIZE_LOW_MASK;
          tk_nxt = in_load_type;
          top_nxt = '0;
          tot_nxt = '0;
          addr_nxt = '0;
          ok_nxt = 1'b0;
          full_nxt = 1'b0;
          idx_nxt = '0;
          phase_nxt = 1'b0;
          unique case (rtpa_pkg::op_t'(in_opcode))
            rtpa_pkg::OP_LOAD: begin
              if (cnt_r < CW'(MAX_REGIONS)) begin
                st_nxt = rtpa_pkg::ST_FIX;
              end else begin
                full_nxt = 1'b1;
                st_nxt = rtpa_pkg::ST_DONE;
              end
            end
            rtpa_pkg::OP_ALIGN: begin
              st_nxt = (in_align_value == '0 || cnt_r == '0) ?
                       rtpa_pkg::ST_DONE : rtpa_pkg::ST_ARD;
            end
            rtpa_pkg::OP_ALLOC: begin
              idx_nxt = cnt_r - CW'(1);
              st_nxt = (rnd_v[64] || cnt_r < CW'(2)) ?
                       rtpa_pkg::ST_DONE : rtpa_pkg::ST_SRD;
            end
            rtpa_pkg::OP_QUERY: begin
              st_nxt = (cnt_r == '0) ? rtpa_pkg::ST_DONE : rtpa_pkg::ST_QRD;
            end
            default: st_nxt = rtpa_pkg::ST_DONE;
          endcase
        end
      end
      rtpa_pkg::ST_ARD: st_nxt = rtpa_pkg::ST_ADIV;
      rtpa_pkg::ST_ADIV: begin
        if (phase_r == 1'b0) begin
          tb_nxt = rb;
          ts_nxt = rs;
          tk_nxt = rk;
          phase_nxt = 1'b1;
        end else if (drsp.done) begin
          if (drsp.rem != '0) begin
            tb_nxt = tb_r + shift_v;
            ts_nxt = sz_v;
          end
          phase_nxt = 1'b0;
          st_nxt = rtpa_pkg::ST_AWR;
        end
      end
      rtpa_pkg::ST_AWR: begin
        if (phase_r == 1'b0) begin
          phase_nxt = 1'b1;
        end else if (drsp.done) begin
          ts_nxt = ts_r - drsp.rem;
          phase_nxt = 1'b0;
          st_nxt = rtpa_pkg::ST_FIX;
        end
      end
      rtpa_pkg::ST_SRD: st_nxt = rtpa_pkg::ST_SCHK;
      rtpa_pkg::ST_SCHK: begin
        if (rk == rtpa_pkg::KIND_FREE && rs >= bytes_r) begin
          if (cnt_r >= CW'(MAX_REGIONS)) begin
            full_nxt = 1'b1;
            st_nxt = rtpa_pkg::ST_DONE;
          end else begin
            hit_nxt = idx_r;
            idx_nxt = cnt_r;
            st_nxt = rtpa_pkg::ST_MRD;
          end
        end else if (idx_r == CW'(1)) begin
          st_nxt = rtpa_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r - CW'(1);
          st_nxt = rtpa_pkg::ST_SRD;
        end
      end
      rtpa_pkg::ST_MRD: st_nxt = rtpa_pkg::ST_MWR;
      rtpa_pkg::ST_MWR: begin
        if (idx_r == hit_r + CW'(1)) begin
          tb_nxt = rb;
          ts_nxt = rs;
          addr_nxt = rb;
          phase_nxt = 1'b1;
          st_nxt = rtpa_pkg::ST_FIX;
        end else begin
          idx_nxt = idx_r - CW'(1);
          st_nxt = rtpa_pkg::ST_MRD;
        end
      end
      rtpa_pkg::ST_FIX: begin
        if (op_r == rtpa_pkg::OP_LOAD) begin
          cnt_nxt = cnt_r + CW'(1);
          st_nxt = rtpa_pkg::ST_DONE;
        end else if (op_r == rtpa_pkg::OP_ALIGN) begin
          if (idx_r + CW'(1) == cnt_r) begin
            st_nxt = rtpa_pkg::ST_DONE;
          end else begin
            idx_nxt = idx_r + CW'(1);
            st_nxt = rtpa_pkg::ST_ARD;
          end
        end else if (phase_r) begin
          phase_nxt = 1'b0;
          idx_nxt = hit_r;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          ok_nxt = 1'b1;
          st_nxt = rtpa_pkg::ST_DONE;
        end
      end
      rtpa_pkg::ST_QRD: st_nxt = rtpa_pkg::ST_QACC;
      rtpa_pkg::ST_QACC: begin
        if (rk == rtpa_pkg::KIND_FREE) begin
          if (sum_v > top_r) top_nxt = sum_v;
          tot_nxt = tot_r + rs;
        end
        if (idx_r + CW'(1) == cnt_r) begin
          st_nxt = rtpa_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + CW'(1);
          st_nxt = rtpa_pkg::ST_QRD;
        end
      end
      rtpa_pkg::ST_DONE: st_nxt = rtpa_pkg::ST_IDLE;
      default: st_nxt = rtpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    ram_addr = idx_r[AW-1:0];
    wb = tb_r;
    ws = ts_r;
    wk = tk_r;
    dreq.start = 1'b0;
    dreq.num = tb_r;
    dreq.den = a_r;
    unique case (st_r)
      rtpa_pkg::ST_ADIV: begin
        dreq.start = (phase_r == 1'b0);
        dreq.num = rb;
      end
      rtpa_pkg::ST_AWR: begin
        dreq.start = (phase_r == 1'b0);
        dreq.num = ts_r;
      end
      rtpa_pkg::ST_MRD: ram_addr = AW'(idx_r - CW'(1));
      rtpa_pkg::ST_MWR: begin
        we = 1'b1;
        wb = rb;
        ws = rs;
        wk = rk;
      end
      rtpa_pkg::ST_FIX: begin
        we = 1'b1;
        if (op_r == rtpa_pkg::OP_LOAD) begin
          ram_addr = cnt_r[AW-1:0];
        end else if (op_r == rtpa_pkg::OP_ALLOC) begin
          if (phase_r) begin
            ram_addr = AW'(hit_r + CW'(1));
            wb = tb_r + bytes_r;
            ws = ts_r - bytes_r;
            wk = rtpa_pkg::KIND_FREE;
          end else begin
            ram_addr = hit_r[AW-1:0];
            wb = addr_r;
            ws = bytes_r;
            wk = rtpa_pkg::KIND_USED;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rtpa_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    op_r <= op_nxt;
    a_r <= a_nxt;
    bytes_r <= bytes_nxt;
    rnd_bad_r <= rnd_bad_nxt;
    phase_r <= phase_nxt;
    tb_r <= tb_nxt;
    ts_r <= ts_nxt;
    tk_r <= tk_nxt;
    top_r <= top_nxt;
    tot_r <= tot_nxt;
    addr_r <= addr_nxt;
    ok_r <= ok_nxt;
    full_r <= full_nxt;
  end

  assign busy = (st_r != rtpa_pkg::ST_IDLE);
  assign out_valid = (st_r == rtpa_pkg::ST_DONE);
  assign out_alloc_address = ok_r ? addr_r : 64'd0;
  assign out_alloc_ok = ok_r & ~rnd_bad_r;
  assign out_table_full = full_r;
  assign out_highest_free_top = top_r;
  assign out_total_free = tot_r;
  assign out_entry_count = 7'(cnt_r);
endmodule

@@ test/tb_region_table_page_allocator_core.sv @@
// tb_region_table_page_allocator_core: self-checking bench for the region table allocator
// depends on rtpa_pkg and region_table_page_allocator_core; predicts every result itself
// directed requests first, then random loads, aligns, allocations and queries, then a full table
module tb_region_table_page_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam logic [1:0] KIND_ACPI = 2'd2;
  localparam logic [1:0] KIND_MMIO = 2'd3;

  typedef struct {
    logic [63:0] alloc_address;
    logic        alloc_ok;
    logic        table_full;
    logic [63:0] highest_free_top;
    logic [63:0] total_free;
    logic [6:0]  entry_count;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [63:0] in_load_base;
  logic [63:0] in_load_size;
  logic [1:0]  in_load_type;
  logic [63:0] in_align_value;
  logic [63:0] in_request_bytes;
  logic        out_valid;
  logic [63:0] out_alloc_address;
  logic        out_alloc_ok;
  logic        out_table_full;
  logic [63:0] out_highest_free_top;
  logic [63:0] out_total_free;
  logic [6:0]  out_entry_count;

  logic [63:0] model_base [TABLE_DEPTH];
  logic [63:0] model_size [TABLE_DEPTH];
  logic [1:0]  model_kind [TABLE_DEPTH];
  int          model_count;

  alloc_result_t pending_results[$];
  int     mismatches;
  longint cycle_count;
  bit     no_gaps;

  region_table_page_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_load_base(in_load_base), .in_load_size(in_load_size),
    .in_load_type(in_load_type), .in_align_value(in_align_value),
    .in_request_bytes(in_request_bytes), .out_valid(out_valid),
    .out_alloc_address(out_alloc_address), .out_alloc_ok(out_alloc_ok),
    .out_table_full(out_table_full), .out_highest_free_top(out_highest_free_top),
    .out_total_free(out_total_free), .out_entry_count(out_entry_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic alloc_result_t apply_request(input rtpa_pkg::op_t op,
      input logic [63:0] lbase, input logic [63:0] lsize, input logic [1:0] ltype,
      input logic [63:0] align_by, input logic [63:0] req);
    alloc_result_t r;
    logic [63:0] rem, shift, bytes, pad, t;
    int hit;
    r = '{64'd0, 1'b0, 1'b0, 64'd0, 64'd0, 7'd0};
    case (op)
      rtpa_pkg::OP_LOAD: begin
        if (model_count < TABLE_DEPTH) begin
          model_base[model_count] = lbase;
          model_size[model_count] = lsize & ~rtpa_pkg::SIZE_LOW_MASK;
          model_kind[model_count] = ltype;
          model_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      rtpa_pkg::OP_ALIGN: begin
        if (align_by != 0) begin
          for (int i = 0; i < model_count; i++) begin
            rem = model_base[i] % align_by;
            if (rem != 0) begin
              shift = align_by - rem;
              model_base[i] += shift;
              model_size[i] = (model_size[i] >= shift) ? model_size[i] - shift : 64'd0;
            end
            model_size[i] -= model_size[i] % align_by;
          end
        end
      end
      rtpa_pkg::OP_ALLOC: begin
        bytes = req;
        rem = req % rtpa_pkg::PAGE_BYTES;
        hit = 1;
        if (rem != 0) begin
          pad = rtpa_pkg::PAGE_BYTES - rem;
          if (bytes > ~64'd0 - pad) hit = 0;
          else bytes += pad;
        end
        if (model_count < 2) hit = 0;
        if (hit) begin
          hit = 0;
          for (int i = model_count - 1; i > 0 && hit == 0; i--) begin
            if (model_kind[i] == rtpa_pkg::KIND_FREE && model_size[i] >= bytes) begin
              hit = 1;
              if (model_count >= TABLE_DEPTH) begin
                r.table_full = 1'b1;
              end else begin
                for (int j = model_count; j > i; j--) begin
                  model_base[j] = model_base[j-1];
                  model_size[j] = model_size[j-1];
                  model_kind[j] = model_kind[j-1];
                end
                model_count++;
                model_kind[i] = rtpa_pkg::KIND_USED;
                model_size[i] = bytes;
                model_base[i+1] += bytes;
                model_size[i+1] -= bytes;
                r.alloc_address = model_base[i];
                r.alloc_ok = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < model_count; i++) begin
          if (model_kind[i] == rtpa_pkg::KIND_FREE) begin
            t = model_base[i] + model_size[i];
            if (t > r.highest_free_top) r.highest_free_top = t;
            r.total_free += model_size[i];
          end
        end
      end
    endcase
    r.entry_count = model_count[6:0];
    return r;
  endfunction

  task automatic send_request(input rtpa_pkg::op_t op, input logic [63:0] lbase,
      input logic [63:0] lsize, input logic [1:0] ltype, input logic [63:0] align_by,
      input logic [63:0] req);
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_load_base = lbase;
    in_load_size = lsize;
    in_load_type = ltype;
    in_align_value = align_by;
    in_request_bytes = req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_request(op, lbase, lsize, ltype, align_by, req));
    idle_gap();
  endtask

  task automatic idle_gap();
    int n;
    if (no_gaps) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_alloc_address !== want.alloc_address)
          report_mismatch("alloc_address", out_alloc_address, want.alloc_address);
        if (out_alloc_ok !== want.alloc_ok)
          report_mismatch("alloc_ok", out_alloc_ok, want.alloc_ok);
        if (out_table_full !== want.table_full)
          report_mismatch("table_full", out_table_full, want.table_full);
        if (out_highest_free_top !== want.highest_free_top)
          report_mismatch("highest_free_top", out_highest_free_top, want.highest_free_top);
        if (out_total_free !== want.total_free)
          report_mismatch("total_free", out_total_free, want.total_free);
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry_count", out_entry_count, want.entry_count);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic load_region(input logic [63:0] b, input logic [63:0] s, input logic [1:0] k);
    send_request(rtpa_pkg::OP_LOAD, b, s, k, rand64(), rand64());
  endtask

  task automatic align_regions(input logic [63:0] a);
    send_request(rtpa_pkg::OP_ALIGN, rand64(), rand64(), 2'($urandom), a, rand64());
  endtask

  task automatic allocate_pages(input logic [63:0] req);
    send_request(rtpa_pkg::OP_ALLOC, rand64(), rand64(), 2'($urandom), rand64(), req);
  endtask

  task automatic query_free();
    send_request(rtpa_pkg::OP_QUERY, rand64(), rand64(), 2'($urandom), rand64(), rand64());
  endtask

  task automatic test_empty_table();
    query_free();
    allocate_pages(64'h1000);
    align_regions(64'd0);
    load_region(64'h0, 64'h1000, rtpa_pkg::KIND_USED);
    allocate_pages(64'h10);
  endtask

  task automatic test_split_and_edges();
    load_region(64'h10000, 64'h1_000F, rtpa_pkg::KIND_FREE);
    allocate_pages(64'd0);
    allocate_pages(64'd1);
    allocate_pages(64'hFFFF_FFFF_FFFF_FFFF);
    allocate_pages(64'hFFFF_FFFF_FFFF_F000);
    load_region(64'h20_0000, 64'h8000, KIND_ACPI);
    load_region(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, KIND_MMIO);
    load_region(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, rtpa_pkg::KIND_FREE);
    load_region(64'h30_0123, 64'h5_0000, rtpa_pkg::KIND_FREE);
    query_free();
    align_regions(64'h1000);
    query_free();
    align_regions(64'h3);
    align_regions(64'h8000_0000_0000_0000);
    align_regions(64'hFFFF_FFFF_FFFF_FFFF);
    allocate_pages(64'h2000);
    query_free();
  endtask

  task automatic test_random_mix();
    int pick;
    logic [63:0] v;
    for (int n = 0; n < 1250; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 12 && model_count < 58) begin
        v = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 1 << 20)) << 12;
        if ($urandom_range(0, 3) == 0) v += $urandom_range(1, 4095);
        load_region(v,
                    ($urandom_range(0, 9) == 0) ? rand64()
                                                : 64'($urandom_range(1, 256)) << 12
                                                  | $urandom_range(0, 4095),
                    ($urandom_range(0, 2) != 0) ? rtpa_pkg::KIND_FREE : 2'($urandom));
      end else if (pick < 18) begin
        case ($urandom_range(0, 5))
          0: v = rand64();
          1: v = $urandom_range(1, 10000);
          default: v = 64'd1 << $urandom_range(0, 16);
        endcase
        align_regions(v);
      end else if (pick < 65) begin
        v = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 1 << 18));
        allocate_pages(v);
      end else begin
        query_free();
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_full_table();
    while (model_count < TABLE_DEPTH)
      load_region(64'($urandom_range(0, 1 << 20)) << 12, 64'h10_0000, rtpa_pkg::KIND_FREE);
    load_region(64'h4000_0000, 64'h1000, rtpa_pkg::KIND_FREE);
    allocate_pages(64'h1000);
    query_free();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = rtpa_pkg::OP_LOAD;
    in_load_base = '0;
    in_load_size = '0;
    in_load_type = rtpa_pkg::KIND_USED;
    in_align_value = 64'd1;
    in_request_bytes = '0;
    mismatches = 0;
    cycle_count = 0;
    no_gaps = 1'b0;
    model_count = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_split_and_edges();
    test_random_mix();
    test_full_table();

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ region_table_page_allocator_core.f @@
design/rtpa_pkg.sv
design/rtpa_ram.sv
design/rtpa_div.sv
design/region_table_page_allocator_core.sv
test/tb_region_table_page_allocator_core.sv
